// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked with reset held too
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/gte_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gte_pkg;
	localparam int unsigned MaxNodesDefault = 1024;
	localparam int unsigned MaxEdgesDefault = 8192;
	localparam int unsigned CmdW = 2;
	localparam int unsigned IndexW = 13;
	localparam int unsigned ValueW = 14;
	localparam int unsigned NodeW = 10;
	localparam int unsigned CountW = 11;

	localparam logic [CmdW-1:0] CMD_LOAD_OFS = 2'd0;
	localparam logic [CmdW-1:0] CMD_LOAD_EDGE = 2'd1;
	localparam logic [CmdW-1:0] CMD_RESTART = 2'd2;
	localparam logic [CmdW-1:0] CMD_STEP = 2'd3;

	localparam logic CFG_NODE_COUNT = 1'b0;
	localparam logic CFG_USE_STACK = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic load_ofs;
		logic load_edge;
		logic restart;
		logic scan_rd;
		logic scan_eval;
		logic pop;
		logic ofs_rd0;
		logic ofs_rd1;
		logic edge_rd;
		logic edge_eval;
		logic emit_node;
		logic emit_done;
		logic clear_wr;
	} gte_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic fill_zero;
		logic scan_end;
		logic scan_hit;
		logic edge_more;
		logic clear_last;
	} gte_sts_t;
endpackage
`default_nettype wire

// ===== rtl/gte_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module gte_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [gte_pkg::CmdW-1:0] command,
	input wire gte_pkg::gte_sts_t sts,
	output logic busy,
	output gte_pkg::gte_cmd_t cmd
);
	import gte_pkg::*;

	typedef enum logic [10:0] {
		ST_CLEAR = 11'b00000000001,
		ST_IDLE = 11'b00000000010,
		ST_SCAN_RD = 11'b00000000100,
		ST_SCAN_EV = 11'b00000001000,
		ST_POP = 11'b00000010000,
		ST_POP_WAIT = 11'b00000100000,
		ST_OFS0 = 11'b00001000000,
		ST_OFS1 = 11'b00010000000,
		ST_EDGE_RD = 11'b00100000000,
		ST_EDGE_EV = 11'b01000000000,
		ST_EMIT = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	assign busy = (state_q != ST_IDLE);

	// next state and command decode
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (sts.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					case (command)
						CMD_LOAD_OFS: cmd.load_ofs = 1'b1;
						CMD_LOAD_EDGE: cmd.load_edge = 1'b1;
						CMD_RESTART: begin
							cmd.restart = 1'b1;
							state_d = ST_CLEAR;
						end
						CMD_STEP: state_d = ST_SCAN_RD;
						default: ;
					endcase
				end
			end
			ST_SCAN_RD: begin
				if (!sts.fill_zero) state_d = ST_POP;
				else if (sts.scan_end) begin
					cmd.emit_done = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d = ST_SCAN_EV;
				end
			end
			ST_SCAN_EV: begin
				cmd.scan_eval = 1'b1;
				state_d = sts.scan_hit ? ST_POP : ST_SCAN_RD;
			end
			ST_POP: begin
				cmd.pop = 1'b1;
				state_d = ST_POP_WAIT;
			end
			ST_POP_WAIT: begin
				cmd.ofs_rd0 = 1'b1;
				state_d = ST_OFS0;
			end
			ST_OFS0: begin
				cmd.ofs_rd1 = 1'b1;
				state_d = ST_OFS1;
			end
			ST_OFS1: state_d = ST_EDGE_RD;
			ST_EDGE_RD: begin
				if (sts.edge_more) begin
					cmd.edge_rd = 1'b1;
					state_d = ST_EDGE_EV;
				end else state_d = ST_EMIT;
			end
			ST_EDGE_EV: begin
				cmd.edge_eval = 1'b1;
				state_d = ST_EDGE_RD;
			end
			ST_EMIT: begin
				cmd.emit_node = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register, clearing pass runs after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	`ASSERT_CLK(a_onehot, clk, arst_n, $onehot(state_q), "state not one-hot")
	`ASSERT_CLK(a_emit_excl, clk, arst_n, !(cmd.emit_node && cmd.emit_done), "double emit")
	`ASSERT_CLK(a_emit_idle, clk, arst_n, (cmd.emit_node || cmd.emit_done) |=> !busy,
		"emit not followed by idle")
endmodule
`default_nettype wire

// ===== rtl/gte_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module gte_dpath #(
	parameter int unsigned MAX_NODES = gte_pkg::MaxNodesDefault,
	parameter int unsigned MAX_EDGES = gte_pkg::MaxEdgesDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire gte_pkg::gte_cmd_t cmd,
	input wire logic [gte_pkg::IndexW-1:0] index,
	input wire logic [gte_pkg::ValueW-1:0] value,
	input wire logic [gte_pkg::CountW-1:0] node_count,
	input wire logic use_stack,
	output gte_pkg::gte_sts_t sts,
	output logic strobe,
	output logic [gte_pkg::NodeW-1:0] node,
	output logic done_res
);
	import gte_pkg::*;

	localparam int unsigned NA = $clog2(MAX_NODES);
	localparam int unsigned EA = $clog2(MAX_EDGES);
	localparam int unsigned NF = $clog2(MAX_NODES + 1);
	localparam int unsigned OA = $clog2(MAX_NODES + 1);
	localparam int unsigned EF = $clog2(MAX_EDGES + 1);
	localparam int unsigned WW = (NF > CountW) ? NF : CountW;
	localparam int unsigned XW = (EF > ValueW) ? EF : ValueW;
	localparam int unsigned SW = NF + 1;

	logic [ValueW-1:0] ofs_mem [MAX_NODES+1];
	logic [NodeW-1:0] edge_mem [MAX_EDGES];
	logic [NodeW-1:0] cont_mem [MAX_NODES];
	logic vis_mem [MAX_NODES];

	logic [NA-1:0] head_q;
	logic [NF-1:0] fill_q;
	logic [NF-1:0] scan_q;
	logic [NA-1:0] clr_q;
	logic [ValueW-1:0] ofs_rd_q;
	logic [NodeW-1:0] edge_rd_q;
	logic [NodeW-1:0] cont_rd_q;
	logic vis_rd_q;
	logic [NodeW-1:0] cur_q;
	logic [EF-1:0] eptr_q, eend_q;
	logic ofs1_q;
	logic [NF-1:0] n_act;
	logic [NA-1:0] vis_addr, push_addr, pop_addr;
	logic [SW-1:0] push_sum, pop_sum;
	logic vis_we, vis_wd, push_en;
	logic [NodeW-1:0] push_val;
	logic [WW-1:0] nc_ext;
	logic [XW-1:0] ofs_ext;
	logic [EF-1:0] ofs_clamp;
	logic nb_ok;

	// active node count, clamped
	assign nc_ext = WW'(node_count);
	assign n_act = (nc_ext > WW'(MAX_NODES)) ? NF'(MAX_NODES) : NF'(node_count);
	assign ofs_ext = XW'(ofs_rd_q);
	assign ofs_clamp = (ofs_ext > XW'(MAX_EDGES)) ? EF'(MAX_EDGES) : EF'(ofs_rd_q);
	assign nb_ok = (NF'(edge_rd_q) < n_act) && (32'(edge_rd_q) < MAX_NODES) && !vis_rd_q;

	assign sts.fill_zero = (fill_q == '0);
	assign sts.scan_end = (scan_q >= n_act);
	assign sts.scan_hit = !vis_rd_q;
	assign sts.edge_more = (eptr_q < eend_q);
	assign sts.clear_last = (clr_q == NA'(MAX_NODES - 1));

	// push decision: root found, or unvisited neighbour
	always_comb begin
		push_en = 1'b0;
		push_val = NodeW'(scan_q);
		if (cmd.scan_eval && !vis_rd_q) push_en = 1'b1;
		if (cmd.edge_eval && nb_ok) begin
			push_en = 1'b1;
			push_val = edge_rd_q;
		end
	end

	// circular buffer addresses, wrapped by one compare and subtract
	assign push_sum = SW'(head_q) + SW'(fill_q);
	assign pop_sum = push_sum - SW'(1);
	assign push_addr = (push_sum >= SW'(MAX_NODES)) ? NA'(push_sum - SW'(MAX_NODES))
		: NA'(push_sum);
	assign pop_addr = !use_stack ? head_q
		: (pop_sum >= SW'(MAX_NODES)) ? NA'(pop_sum - SW'(MAX_NODES)) : NA'(pop_sum);

	// visited map port select
	always_comb begin
		vis_we = 1'b0;
		vis_wd = 1'b1;
		vis_addr = NA'(scan_q);
		if (cmd.clear_wr) begin
			vis_we = 1'b1;
			vis_wd = 1'b0;
			vis_addr = clr_q;
		end else if (push_en) begin
			vis_we = 1'b1;
			vis_addr = NA'(push_val);
		end else if (cmd.edge_rd) vis_addr = NA'(edge_rd_q);
		else if (cmd.scan_rd) vis_addr = NA'(scan_q);
	end

	// visited map memory
	always_ff @(posedge clk) begin
		if (vis_we) vis_mem[vis_addr] <= vis_wd;
		vis_rd_q <= vis_mem[vis_addr];
	end

	// tables
	always_ff @(posedge clk) begin
		if (cmd.load_ofs && 32'(index) <= MAX_NODES) ofs_mem[OA'(index)] <= value;
		if (cmd.ofs_rd0) ofs_rd_q <= ofs_mem[OA'(cont_rd_q)];
		else if (cmd.ofs_rd1) ofs_rd_q <= ofs_mem[OA'(cur_q) + 1'b1];
	end
	always_ff @(posedge clk) begin
		if (cmd.load_edge && 32'(index) < MAX_EDGES) edge_mem[EA'(index)] <= value[NodeW-1:0];
		edge_rd_q <= edge_mem[EA'(eptr_q)];
	end
	always_ff @(posedge clk) begin
		if (push_en && fill_q < NF'(MAX_NODES)) cont_mem[push_addr] <= push_val;
		cont_rd_q <= cont_mem[pop_addr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
			scan_q <= '0;
			clr_q <= '0;
			strobe <= 1'b0;
			done_res <= 1'b0;
		end else begin
			strobe <= cmd.emit_node || cmd.emit_done;
			done_res <= cmd.emit_done;
			if (cmd.clear_wr) clr_q <= clr_q + 1'b1;
			if (cmd.restart) begin
				head_q <= '0;
				fill_q <= '0;
				scan_q <= '0;
				clr_q <= '0;
			end
			if (cmd.scan_eval) scan_q <= scan_q + 1'b1;
			if (cmd.pop) begin
				fill_q <= fill_q - 1'b1;
				if (!use_stack) head_q <= (head_q == NA'(MAX_NODES - 1)) ? '0 : head_q + 1'b1;
			end else if (push_en && fill_q < NF'(MAX_NODES)) fill_q <= fill_q + 1'b1;
		end
	end

	// offset read stage marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ofs1_q <= 1'b0;
		else ofs1_q <= cmd.ofs_rd1;
	end

	// traversal payload
	always_ff @(posedge clk) begin
		if (cmd.ofs_rd0) cur_q <= cont_rd_q;
		if (cmd.ofs_rd1) eptr_q <= ofs_clamp;
		if (cmd.edge_rd) eptr_q <= eptr_q + 1'b1;
		if (ofs1_q) eend_q <= ofs_clamp;
		if (cmd.emit_node) node <= cur_q;
		if (cmd.emit_done) node <= '0;
	end

	`ASSERT_CLK(a_fill_rng, clk, arst_n, fill_q <= NF'(MAX_NODES), "fill overflow")
	`ASSERT_CLK(a_pop_nonempty, clk, arst_n, cmd.pop |-> fill_q != '0, "pop on empty")
	`ASSERT_CLK(a_done_strobe, clk, arst_n, done_res |-> strobe, "done without strobe")
endmodule
`default_nettype wire

// ===== rtl/graph_traversal_engine_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Graph traversal engine over a compressed-row graph. Commands are taken when start is
// high and busy low; load and restart give no result, a step gives one result on the
// strobe for one cycle, which the receiver cannot stall. Loads do not raise busy. After
// reset and after each restart a clearing pass wipes all MAX_NODES entries of the visited
// map while busy is high. A step that pops a waiting node reads its two offsets, walks
// its edge slots one at a time through the one-port visited map, and emits it; with an
// empty container it first scans the visited map for an unvisited root, and a step that
// finds every node visited ends with done_res.
module graph_traversal_engine_top #(
	parameter int unsigned MAX_NODES = gte_pkg::MaxNodesDefault,
	parameter int unsigned MAX_EDGES = gte_pkg::MaxEdgesDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [gte_pkg::CmdW-1:0] command,
	input wire logic [gte_pkg::IndexW-1:0] index,
	input wire logic [gte_pkg::ValueW-1:0] value,
	output logic strobe,
	output logic [gte_pkg::NodeW-1:0] node,
	output logic done_res,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [gte_pkg::CountW-1:0] cfg_data
);
	import gte_pkg::*;

	gte_cmd_t cmd;
	gte_sts_t sts;
	logic [CountW-1:0] node_count_q;
	logic use_stack_q;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
			use_stack_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_NODE_COUNT: node_count_q <= cfg_data;
				CFG_USE_STACK: use_stack_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	gte_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .command(command),
		.sts(sts), .busy(busy), .cmd(cmd)
	);

	gte_dpath #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .index(index), .value(value),
		.node_count(node_count_q), .use_stack(use_stack_q), .sts(sts),
		.strobe(strobe), .node(node), .done_res(done_res)
	);
endmodule
`default_nettype wire

// ===== tb/graph_traversal_engine_top_tb.sv =====
`timescale 1ns / 1ps
module graph_traversal_engine_top_tb;
	import gte_pkg::*;

	localparam int NODE_LIM = 1024;
	localparam int EDGE_LIM = 8192;

	typedef struct {
		bit is_cfg;
		logic [CmdW-1:0] cmd;
		int idx;
		int val;
		bit has_exp;
		logic [NodeW-1:0] e_node;
		logic e_done;
	} row_t;

	typedef struct {
		logic [NodeW-1:0] node;
		logic done;
	} visit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [CmdW-1:0] command = '0;
	logic [IndexW-1:0] index = '0;
	logic [ValueW-1:0] value = '0;
	logic cfg_valid = 1'b0;
	logic cfg_index = 1'b0;
	logic [CountW-1:0] cfg_data = '0;
	logic busy, strobe, done_res, cfg_ready;
	logic [NodeW-1:0] node;

	// shadow of the traversal state
	logic [ValueW-1:0] ofs_tab [0:NODE_LIM];
	logic [NodeW-1:0] edge_tab [0:EDGE_LIM-1];
	bit visited [0:NODE_LIM-1];
	logic [NodeW-1:0] cstore [0:NODE_LIM-1];
	int head, fill, scan;
	int ncount;
	bit stack_mode;

	visit_t visit_q[$];
	row_t dir_q[$];
	int errors = 0;
	int sent = 0;
	bit calm = 1'b0;

	graph_traversal_engine_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .index(index), .value(value),
		.strobe(strobe), .node(node), .done_res(done_res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mark a node and append it to the container
	function automatic void mark_push(int v);
		visited[v] = 1'b1;
		if (fill < NODE_LIM) begin
			cstore[(head + fill) % NODE_LIM] = v[NodeW-1:0];
			fill++;
		end
	endfunction

	function automatic void clear_walk();
		foreach (visited[i]) visited[i] = 1'b0;
		head = 0;
		fill = 0;
		scan = 0;
	endfunction

	// next node in traversal order, or done
	function automatic void next_visit(output logic [NodeW-1:0] nd, output logic dn);
		int n_act, v, st, en, nb;
		n_act = ncount > NODE_LIM ? NODE_LIM : ncount;
		nd = '0;
		dn = 1'b0;
		if (fill == 0) begin
			while (scan < n_act && visited[scan]) scan++;
			if (scan >= n_act) begin
				dn = 1'b1;
				return;
			end
			mark_push(scan);
			scan++;
		end
		if (stack_mode) begin
			v = cstore[(head + fill - 1) % NODE_LIM];
		end else begin
			v = cstore[head];
			head = (head + 1) % NODE_LIM;
		end
		fill--;
		st = ofs_tab[v];
		en = ofs_tab[v + 1];
		if (st > EDGE_LIM) st = EDGE_LIM;
		if (en > EDGE_LIM) en = EDGE_LIM;
		for (int e = st; e < en; e++) begin
			nb = edge_tab[e];
			if (nb < n_act && !visited[nb]) mark_push(nb);
		end
		nd = v[NodeW-1:0];
	endfunction

	// idle gap before an item, mostly short
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// issue one item and predict its effect once accepted
	task automatic send_item(input logic [CmdW-1:0] cmd, input int idx, input int val,
			input bit has_exp = 1'b0, input logic [NodeW-1:0] e_node = '0,
			input logic e_done = 1'b0);
		int gap;
		logic [NodeW-1:0] nd;
		logic dn;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		index <= idx[IndexW-1:0];
		value <= val[ValueW-1:0];
		do @(posedge clk); while (busy);
		case (cmd)
			CMD_LOAD_OFS: begin
				if (idx <= NODE_LIM) ofs_tab[idx] = val[ValueW-1:0];
			end
			CMD_LOAD_EDGE: begin
				edge_tab[idx] = val[NodeW-1:0];
			end
			CMD_RESTART: begin
				clear_walk();
			end
			default: begin
				next_visit(nd, dn);
				if (has_exp) visit_q.push_back('{e_node, e_done});
				else visit_q.push_back('{nd, dn});
			end
		endcase
		if (!(cmd == CMD_LOAD_OFS && idx > NODE_LIM)) sent++;
	endtask

	// stop issuing and wait until the block has nothing left in flight
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (visit_q.size() != 0 || busy);
		repeat (8) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(input logic ridx, input int data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= ridx;
		cfg_data <= data[CountW-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (ridx == CFG_NODE_COUNT) ncount = data[CountW-1:0];
		else stack_mode = data[0];
		@(posedge clk);
	endtask

	// load offsets 0..n and every edge slot their ranges can reach
	task automatic build_graph(input int n, input int dmax);
		int base, prev, lo, hi, o;
		base = $urandom_range(0, EDGE_LIM - n * dmax - 8);
		prev = base;
		lo = base;
		hi = base;
		for (int v = 0; v <= n; v++) begin
			if (v == 0) o = base;
			else if ($urandom_range(0, 9) == 0) o = prev - $urandom_range(0, prev < 3 ? prev : 3);
			else o = prev + $urandom_range(0, dmax);
			if (o > EDGE_LIM) o = EDGE_LIM;
			if (o < lo) lo = o;
			if (o > hi) hi = o;
			send_item(CMD_LOAD_OFS, v, o);
			prev = o;
		end
		for (int s = lo; s < hi; s++) begin
			if (n > 0 && $urandom_range(0, 4) != 0)
				send_item(CMD_LOAD_EDGE, s, $urandom_range(0, n - 1));
			else
				send_item(CMD_LOAD_EDGE, s, $urandom_range(0, 16383));
		end
	endtask

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		visit_t want;
		if (arst_n && strobe) begin
			if (visit_q.size() == 0) begin
				$error("result with no step pending: node %0d done %0b", node, done_res);
				errors++;
			end else begin
				want = visit_q.pop_front();
				if (done_res !== want.done) begin
					$error("done_res expected %0b actual %0b", want.done, done_res);
					errors++;
				end else if (!want.done && node !== want.node) begin
					$error("node expected %0d actual %0d", want.node, node);
					errors++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		row_t r;
		int n, steps, k;
		foreach (ofs_tab[i]) ofs_tab[i] = '0;
		foreach (edge_tab[i]) edge_tab[i] = '0;
		foreach (cstore[i]) cstore[i] = '0;
		clear_walk();
		ncount = 0;
		stack_mode = 1'b0;

		// directed: empty graph, ignored offset loads, top edge slot, small graph with the corner ranges
		dir_q.push_back('{0, CMD_STEP, 0, 0, 1, 0, 1});
		dir_q.push_back('{0, CMD_LOAD_OFS, 1025, 5, 0, 0, 0});
		dir_q.push_back('{0, CMD_LOAD_OFS, 8191, 16383, 0, 0, 0});
		dir_q.push_back('{0, CMD_LOAD_EDGE, 8191, 16383, 0, 0, 0});
		dir_q.push_back('{1, '0, CFG_NODE_COUNT, 5, 0, 0, 0});
		dir_q.push_back('{0, CMD_LOAD_OFS, 0, 16383, 0, 0, 0});
		dir_q.push_back('{0, CMD_LOAD_OFS, 1, 9000, 0, 0, 0});
		dir_q.push_back('{0, CMD_LOAD_OFS, 2, 0, 0, 0, 0});
		dir_q.push_back('{0, CMD_LOAD_OFS, 3, 2, 0, 0, 0});
		dir_q.push_back('{0, CMD_LOAD_OFS, 4, 4, 0, 0, 0});
		dir_q.push_back('{0, CMD_LOAD_OFS, 5, 4, 0, 0, 0});
		dir_q.push_back('{0, CMD_LOAD_EDGE, 0, 4, 0, 0, 0});
		dir_q.push_back('{0, CMD_LOAD_EDGE, 1, 1027, 0, 0, 0});
		dir_q.push_back('{0, CMD_LOAD_EDGE, 2, 1, 0, 0, 0});
		dir_q.push_back('{0, CMD_LOAD_EDGE, 3, 7, 0, 0, 0});
		dir_q.push_back('{0, CMD_STEP, 0, 0, 1, 0, 0});
		dir_q.push_back('{0, CMD_STEP, 0, 0, 1, 1, 0});
		dir_q.push_back('{0, CMD_STEP, 0, 0, 1, 2, 0});
		dir_q.push_back('{0, CMD_STEP, 0, 0, 1, 4, 0});
		dir_q.push_back('{0, CMD_STEP, 0, 0, 1, 3, 0});
		dir_q.push_back('{0, CMD_STEP, 0, 0, 1, 0, 1});
		dir_q.push_back('{1, '0, CFG_USE_STACK, 1, 0, 0, 0});
		dir_q.push_back('{0, CMD_RESTART, 0, 0, 0, 0, 0});
		dir_q.push_back('{0, CMD_STEP, 0, 0, 1, 0, 0});
		dir_q.push_back('{0, CMD_STEP, 0, 0, 1, 1, 0});
		dir_q.push_back('{0, CMD_STEP, 0, 0, 1, 2, 0});
		dir_q.push_back('{0, CMD_STEP, 0, 0, 1, 3, 0});
		dir_q.push_back('{0, CMD_STEP, 0, 0, 1, 4, 0});
		dir_q.push_back('{0, CMD_STEP, 0, 0, 1, 0, 1});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_q[i]) begin
			r = dir_q[i];
			if (r.is_cfg) write_reg(r.idx[0], r.val);
			else send_item(r.cmd, r.idx, r.val, r.has_exp, r.e_node, r.e_done);
		end

		// random graphs, each traversed from a fresh restart
		while (sent < 860) begin
			calm = ($urandom_range(0, 4) == 0);
			k = $urandom_range(0, 9);
			if (k == 0) n = 0;
			else if (k == 1) n = $urandom_range(1, 3);
			else n = $urandom_range(2, 40);
			build_graph(n, $urandom_range(1, 4));
			write_reg(CFG_NODE_COUNT, n);
			write_reg(CFG_USE_STACK, $urandom_range(0, 1));
			send_item(CMD_RESTART, 0, 0);
			steps = $urandom_range(1, n + 4);
			for (int s = 0; s < steps; s++) begin
				k = $urandom_range(0, 29);
				if (k == 0) send_item(CMD_RESTART, $urandom_range(0, 8191), $urandom_range(0, 16383));
				else if (k == 1) send_item(CMD_LOAD_EDGE, $urandom_range(0, 8191),
						$urandom_range(0, 16383));
				else if (k == 2) send_item(CMD_LOAD_OFS, $urandom_range(1025, 8191),
						$urandom_range(0, 16383));
				else if (k == 3 && s == steps / 2) begin
					// change mode or shrink the graph mid-traversal
					if ($urandom_range(0, 1)) write_reg(CFG_USE_STACK, !stack_mode);
					else write_reg(CFG_NODE_COUNT, $urandom_range(0, n));
				end else send_item(CMD_STEP, $urandom_range(0, 8191), $urandom_range(0, 16383));
			end
		end

		// oversized node count over single-slot nodes that point low, then a mode change
		calm = 1'b0;
		for (int v = 0; v <= 81; v++) send_item(CMD_LOAD_OFS, v, v);
		for (int s = 0; s <= 80; s++) send_item(CMD_LOAD_EDGE, s, $urandom_range(0, 80));
		write_reg(CFG_NODE_COUNT, 2047);
		write_reg(CFG_USE_STACK, 0);
		send_item(CMD_RESTART, 0, 0);
		repeat (40) send_item(CMD_STEP, 0, 0);
		write_reg(CFG_NODE_COUNT, NODE_LIM);
		write_reg(CFG_USE_STACK, 1);
		repeat (30) send_item(CMD_STEP, 0, 0);

		drain();
		repeat (50) @(posedge clk);
		if (errors == 0 && visit_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/gte_pkg.sv
rtl/gte_ctrl.sv
rtl/gte_dpath.sv
rtl/graph_traversal_engine_top.sv
tb/graph_traversal_engine_top_tb.sv
